@@ rtl/riscv_atomic_amo_lr_sc_unit_top_assert.svh @@
// assertion macros for the atomic unit
// used by files that carry concurrent assertions; no other dependencies
`ifndef RISCV_ATOMIC_AMO_LR_SC_UNIT_TOP_ASSERT_SVH
`define RISCV_ATOMIC_AMO_LR_SC_UNIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define RVAMO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define RVAMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RVAMO_ASSERT(label, clk, rst_n, prop, msg)

`define RVAMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/rvamo_pkg.sv @@
// shared types and constants of the atomic unit
// no dependencies
package rvamo_pkg;

    localparam int DATA_W          = 64;
    localparam int WORD_W          = 32;
    localparam int HART_IDX_W      = 2;
    localparam int HART_COUNT_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [3:0] {
        OP_LR   = 4'd0,
        OP_SC   = 4'd1,
        OP_SWAP = 4'd2,
        OP_ADD  = 4'd3,
        OP_XOR  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_MIN  = 4'd7,
        OP_MAX  = 4'd8,
        OP_MINU = 4'd9,
        OP_MAXU = 4'd10
    } t_op;

    typedef struct packed {
        logic [3:0]            req_type;
        logic                  is_double;
        logic [HART_IDX_W-1:0] hart_index;
        logic [DATA_W-1:0]     address;
        logic [DATA_W-1:0]     operand;
        logic [DATA_W-1:0]     mem_data;
        logic                  load_fault;
        logic                  store_fault;
    } t_req;

    typedef struct packed {
        logic              store_enable;
        logic [DATA_W-1:0] store_data;
        logic              rd_enable;
        logic [DATA_W-1:0] rd_value;
        logic              access_fault;
    } t_rsp;

    typedef struct packed {
        logic              op_ok;
        t_op               op;
        logic              is_double;
        logic              load_fault;
        logic              store_fault;
        logic              sc_ok;
        logic [DATA_W-1:0] opa;
        logic [DATA_W-1:0] opb;
    } t_cmd;

endpackage

@@ rtl/riscv_atomic_amo_lr_sc_unit_top.sv @@
// RISC-V A-extension atomic unit, top level
// depends on rvamo_pkg, rvamo_front, rvamo_fifo and rvamo_back

// Takes one atomic operation (LR, SC or an AMO, word or doubleword) per cycle
// when full is low and returns one result beat for each. A pushed beat is held
// in the queue, then the result register, until popped; the steady rate is one
// beat per cycle while pop keeps up, set by the combinational reservation
// lookup in the front end and ALU in the back end. The front end resolves
// LR/SC against the per-hart reservations (compared in parallel across all
// harts) as each beat is accepted, so reservation state always follows input
// order. A queue of QUEUE_DEPTH entries plus one result register separate the
// two sides, so full rises only once that many beats wait unpopped.
module riscv_atomic_amo_lr_sc_unit_top
    import rvamo_pkg::*;
#(
    parameter int HART_COUNT  = HART_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_req i_req,
    output logic empty,
    input  logic pop,
    output t_rsp o_rsp
);

    logic accept;
    t_cmd front_cmd;
    t_cmd back_cmd;
    logic q_valid;
    logic q_pop;

    assign accept = push && !full;

    rvamo_front #(
        .HART_COUNT (HART_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_cmd    (front_cmd)
    );

    rvamo_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (back_cmd)
    );

    rvamo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_rsp       (o_rsp)
    );

endmodule

@@ rtl/rvamo_front.sv @@
// front end: decodes each beat, keeps the per-hart reservations, resolves sc
// depends on rvamo_pkg
module rvamo_front
    import rvamo_pkg::*;
#(
    parameter int HART_COUNT = HART_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_req i_req,
    output t_cmd o_cmd
);

    logic [HART_COUNT-1:0] r_resv_valid;
    logic [HART_COUNT-1:0] n_resv_valid;
    logic [DATA_W-1:0]     r_resv_addr [HART_COUNT];
    logic [HART_COUNT-1:0] r_resv_dbl;

    logic [HART_COUNT-1:0] hart_sel;
    logic [HART_COUNT-1:0] addr_hit;
    logic [HART_COUNT-1:0] own_hit;
    logic                  hart_ok;
    logic                  sc_ok;
    logic                  is_lr;
    logic                  is_sc;
    logic                  lr_set;

    function automatic logic [DATA_W-1:0] sext_word(input logic [DATA_W-1:0] v,
                                                    input logic dbl);
        sext_word = dbl ? v : {{(DATA_W-WORD_W){v[WORD_W-1]}}, v[WORD_W-1:0]};
    endfunction

    always_comb begin
        hart_ok = int'(i_req.hart_index) < HART_COUNT;
        for (int i = 0; i < HART_COUNT; i++) begin
            hart_sel[i] = hart_ok && (int'(i_req.hart_index) == i);
            addr_hit[i] = r_resv_valid[i] && (r_resv_addr[i] == i_req.address);
            own_hit[i]  = hart_sel[i] && addr_hit[i] && (r_resv_dbl[i] == i_req.is_double);
        end
        sc_ok  = |own_hit;
        is_lr  = i_req.req_type == OP_LR;
        is_sc  = i_req.req_type == OP_SC;
        lr_set = i_accept && is_lr && !i_req.load_fault;
    end

    // reservation update
    always_comb begin
        n_resv_valid = r_resv_valid;
        if (i_accept && is_sc) begin
            if (sc_ok) begin
                if (!i_req.store_fault) begin
                    n_resv_valid = r_resv_valid & ~addr_hit;
                end
            end else begin
                n_resv_valid = r_resv_valid & ~hart_sel;
            end
        end
        if (lr_set) begin
            n_resv_valid = n_resv_valid | hart_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv_valid <= '0;
        end else begin
            r_resv_valid <= n_resv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HART_COUNT; i++) begin
            if (lr_set && hart_sel[i]) begin
                r_resv_addr[i] <= i_req.address;
                r_resv_dbl[i]  <= i_req.is_double;
            end
        end
    end

    always_comb begin
        o_cmd.op_ok       = i_req.req_type <= OP_MAXU;
        o_cmd.op          = t_op'(i_req.req_type);
        o_cmd.is_double   = i_req.is_double;
        o_cmd.load_fault  = i_req.load_fault;
        o_cmd.store_fault = i_req.store_fault;
        o_cmd.sc_ok       = sc_ok;
        o_cmd.opa         = sext_word(i_req.mem_data, i_req.is_double);
        o_cmd.opb         = sext_word(i_req.operand, i_req.is_double);
    end

endmodule

@@ rtl/rvamo_fifo.sv @@
// command queue between front end and back end
// depends on rvamo_pkg and the assertion macro header
`include "riscv_atomic_amo_lr_sc_unit_top_assert.svh"
module rvamo_fifo
    import rvamo_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        do_push  = i_push && !o_full;
        do_pop   = i_pop && o_valid;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    `RVAMO_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue overfilled")
    `RVAMO_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "queue count missed a push")
    `RVAMO_ASSERT_NEXT(a_count_dn, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(r_count) - 1'b1, "queue count missed a pop")

endmodule

@@ rtl/rvamo_back.sv @@
// back end: alu for the amo ops, result forming and the result register
// depends on rvamo_pkg
module rvamo_back
    import rvamo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_rsp o_rsp
);

    logic              r_valid;
    logic              n_valid;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic              take;
    logic              slt;
    logic              ult;
    logic [DATA_W-1:0] alu;

    function automatic logic [DATA_W-1:0] mask_word(input logic [DATA_W-1:0] v,
                                                    input logic dbl);
        mask_word = dbl ? v : {{(DATA_W-WORD_W){1'b0}}, v[WORD_W-1:0]};
    endfunction

    always_comb begin
        slt = $signed(i_cmd.opa) < $signed(i_cmd.opb);
        ult = i_cmd.opa < i_cmd.opb;
        unique case (i_cmd.op)
            OP_ADD:  alu = i_cmd.opa + i_cmd.opb;
            OP_XOR:  alu = i_cmd.opa ^ i_cmd.opb;
            OP_AND:  alu = i_cmd.opa & i_cmd.opb;
            OP_OR:   alu = i_cmd.opa | i_cmd.opb;
            OP_MIN:  alu = slt ? i_cmd.opa : i_cmd.opb;
            OP_MAX:  alu = slt ? i_cmd.opb : i_cmd.opa;
            OP_MINU: alu = ult ? i_cmd.opa : i_cmd.opb;
            OP_MAXU: alu = ult ? i_cmd.opb : i_cmd.opa;
            default: alu = i_cmd.opb;
        endcase
    end

    always_comb begin
        n_rsp = '0;
        if (i_cmd.op_ok) begin
            unique case (i_cmd.op)
                OP_LR: begin
                    if (i_cmd.load_fault) begin
                        n_rsp.access_fault = 1'b1;
                    end else begin
                        n_rsp.rd_enable = 1'b1;
                        n_rsp.rd_value  = i_cmd.opa;
                    end
                end
                OP_SC: begin
                    if (i_cmd.sc_ok) begin
                        n_rsp.store_enable = 1'b1;
                        n_rsp.store_data   = mask_word(i_cmd.opb, i_cmd.is_double);
                        if (i_cmd.store_fault) begin
                            n_rsp.access_fault = 1'b1;
                        end else begin
                            n_rsp.rd_enable = 1'b1;
                        end
                    end else begin
                        n_rsp.rd_enable = 1'b1;
                        n_rsp.rd_value  = DATA_W'(1);
                    end
                end
                default: begin
                    if (i_cmd.load_fault) begin
                        n_rsp.access_fault = 1'b1;
                    end else begin
                        n_rsp.store_enable = 1'b1;
                        n_rsp.store_data   = mask_word(alu, i_cmd.is_double);
                        if (i_cmd.store_fault) begin
                            n_rsp.access_fault = 1'b1;
                        end else begin
                            n_rsp.rd_enable = 1'b1;
                            n_rsp.rd_value  = i_cmd.opa;
                        end
                    end
                end
            endcase
        end
    end

    // result register takes a new beat whenever it is free or being drained
    always_comb begin
        take    = i_cmd_valid && (!r_valid || i_pop);
        n_valid = take || (r_valid && !i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_cmd_pop = take;
    assign o_empty   = !r_valid;
    assign o_rsp     = r_rsp;

endmodule

@@ bench/riscv_atomic_amo_lr_sc_unit_top_test.sv @@
`timescale 1ns / 100ps
// testbench for the atomic unit: drives LR/SC/AMO beats through the queue handshake
// and checks every result beat against a built-in predictor of the reservations and ALU
// depends on rvamo_pkg and riscv_atomic_amo_lr_sc_unit_top
module riscv_atomic_amo_lr_sc_unit_top_test;
    import rvamo_pkg::*;

    localparam int NUM_HARTS = HART_COUNT_DEF;
    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_BEATS = 1350;
    localparam int MAX_IDLE = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int POOL_SIZE = 4;
    localparam logic [3:0] OP_CODE_TOP = 4'hF;

    class amo_checker;
        logic              resv_valid [NUM_HARTS];
        logic [DATA_W-1:0] resv_addr [NUM_HARTS];
        logic              resv_dbl [NUM_HARTS];
        t_rsp              pending_rsp [$];
        int                mismatches;
        int                results_seen;

        function new();
            for (int h = 0; h < NUM_HARTS; h++) begin
                resv_valid[h] = 1'b0;
                resv_addr[h] = '0;
                resv_dbl[h] = 1'b0;
            end
            mismatches = 0;
            results_seen = 0;
        endfunction

        function logic [DATA_W-1:0] sext_word(logic [DATA_W-1:0] v);
            return {{(DATA_W-WORD_W){v[WORD_W-1]}}, v[WORD_W-1:0]};
        endfunction

        function logic [DATA_W-1:0] zext_word(logic [DATA_W-1:0] v);
            return {{(DATA_W-WORD_W){1'b0}}, v[WORD_W-1:0]};
        endfunction

        function void note_request(t_req r);
            t_rsp              exp_rsp;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] new_val;
            logic              hart_ok;
            logic              hit;
            exp_rsp = '0;
            hart_ok = int'(r.hart_index) < NUM_HARTS;
            case (r.req_type)
                OP_LR: begin
                    if (r.load_fault) begin
                        exp_rsp.access_fault = 1'b1;
                    end else begin
                        exp_rsp.rd_enable = 1'b1;
                        exp_rsp.rd_value = r.is_double ? r.mem_data : sext_word(r.mem_data);
                        if (hart_ok) begin
                            resv_valid[r.hart_index] = 1'b1;
                            resv_addr[r.hart_index] = r.address;
                            resv_dbl[r.hart_index] = r.is_double;
                        end
                    end
                end
                OP_SC: begin
                    hit = 1'b0;
                    if (hart_ok)
                        hit = resv_valid[r.hart_index] && resv_addr[r.hart_index] == r.address
                              && resv_dbl[r.hart_index] == r.is_double;
                    if (hit) begin
                        exp_rsp.store_enable = 1'b1;
                        exp_rsp.store_data = r.is_double ? r.operand : zext_word(r.operand);
                        if (r.store_fault) begin
                            exp_rsp.access_fault = 1'b1;
                        end else begin
                            for (int h = 0; h < NUM_HARTS; h++)
                                if (resv_valid[h] && resv_addr[h] == r.address)
                                    resv_valid[h] = 1'b0;
                            exp_rsp.rd_enable = 1'b1;
                        end
                    end else begin
                        if (hart_ok)
                            resv_valid[r.hart_index] = 1'b0;
                        exp_rsp.rd_enable = 1'b1;
                        exp_rsp.rd_value = DATA_W'(1);
                    end
                end
                OP_SWAP, OP_ADD, OP_XOR, OP_AND, OP_OR, OP_MIN, OP_MAX, OP_MINU, OP_MAXU: begin
                    if (r.load_fault) begin
                        exp_rsp.access_fault = 1'b1;
                    end else begin
                        a = r.is_double ? r.mem_data : sext_word(r.mem_data);
                        b = r.is_double ? r.operand : sext_word(r.operand);
                        case (r.req_type)
                            OP_SWAP: new_val = b;
                            OP_ADD:  new_val = a + b;
                            OP_XOR:  new_val = a ^ b;
                            OP_AND:  new_val = a & b;
                            OP_OR:   new_val = a | b;
                            OP_MIN:  new_val = ($signed(a) < $signed(b)) ? a : b;
                            OP_MAX:  new_val = ($signed(a) < $signed(b)) ? b : a;
                            OP_MINU: new_val = (a < b) ? a : b;
                            default: new_val = (a < b) ? b : a;
                        endcase
                        exp_rsp.store_enable = 1'b1;
                        exp_rsp.store_data = r.is_double ? new_val : zext_word(new_val);
                        if (r.store_fault) begin
                            exp_rsp.access_fault = 1'b1;
                        end else begin
                            exp_rsp.rd_enable = 1'b1;
                            exp_rsp.rd_value = a;
                        end
                    end
                end
                default: ;
            endcase
            pending_rsp.push_back(exp_rsp);
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp_val);
            if (got !== exp_val)
                flag_mismatch($sformatf("result %0d %s got %h expected %h",
                                        results_seen, name, got, exp_val));
        endtask

        task check_result(t_rsp got);
            t_rsp exp_rsp;
            results_seen++;
            if (pending_rsp.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                exp_rsp = pending_rsp.pop_front();
                compare_field("store_enable", DATA_W'(got.store_enable),
                              DATA_W'(exp_rsp.store_enable));
                compare_field("store_data", got.store_data, exp_rsp.store_data);
                compare_field("rd_enable", DATA_W'(got.rd_enable), DATA_W'(exp_rsp.rd_enable));
                compare_field("rd_value", got.rd_value, exp_rsp.rd_value);
                compare_field("access_fault", DATA_W'(got.access_fault),
                              DATA_W'(exp_rsp.access_fault));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_req i_req = '0;
    logic full;
    logic empty;
    t_rsp o_rsp;

    int cycle_count = 0;
    logic sender_burst = 1'b0;
    logic receiver_burst = 1'b0;
    amo_checker board = new();

    riscv_atomic_amo_lr_sc_unit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (push && !full)
                board.note_request(i_req);
            if (pop && !empty)
                board.check_result(o_rsp);
        end
    end

    function automatic t_req make_req(logic [3:0] op, logic dbl, logic [HART_IDX_W-1:0] hart,
                                      logic [DATA_W-1:0] addr, logic [DATA_W-1:0] opnd,
                                      logic [DATA_W-1:0] mem, logic lf, logic sf);
        t_req r;
        r.req_type = op;
        r.is_double = dbl;
        r.hart_index = hart;
        r.address = addr;
        r.operand = opnd;
        r.mem_data = mem;
        r.load_fault = lf;
        r.store_fault = sf;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_data();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h0000_0000_8000_0000;
            4: return 64'h7FFF_FFFF_FFFF_FFFF;
            5: return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one beat per call, holding push high across back-to-back beats
    task automatic send_beat(t_req r);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(negedge i_clk); while (board.pending_rsp.size() > 0);
    endtask

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = receiver_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 49) == 0)
                receiver_burst = !receiver_burst;
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [DATA_W-1:0]     addr_pool [POOL_SIZE];
        logic [DATA_W-1:0]     lr_addr [NUM_HARTS];
        logic                  lr_dbl [NUM_HARTS];
        logic [DATA_W-1:0]     base;
        logic [HART_IDX_W-1:0] hart;
        t_req                  beat;
        int                    pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        base = {$urandom, $urandom} & ~64'h3F;
        // reservation rules
        send_beat(make_req(OP_SC, 1'b0, '0, '0, rand_data(), rand_data(), 1'b0, 1'b0));
        send_beat(make_req(OP_LR, 1'b0, '0, '1, '0, 64'h0000_0000_8000_0000, 1'b0, 1'b0));
        send_beat(make_req(OP_SC, 1'b1, '0, '1, '1, '0, 1'b0, 1'b0));
        send_beat(make_req(OP_LR, 1'b1, '0, '1, '0, '1, 1'b0, 1'b0));
        send_beat(make_req(OP_SC, 1'b1, '0, '1, '1, '0, 1'b0, 1'b1));
        send_beat(make_req(OP_SC, 1'b1, '0, '1, 64'h8000_0000_0000_0001, '0, 1'b0, 1'b0));
        send_beat(make_req(OP_LR, 1'b0, 2'd1, base, '0, 64'h7FFF_FFFF, 1'b0, 1'b0));
        send_beat(make_req(OP_LR, 1'b1, 2'd2, base, '0, '1, 1'b0, 1'b0));
        send_beat(make_req(OP_LR, 1'b0, '1, base + 8, '0, '0, 1'b0, 1'b0));
        send_beat(make_req(OP_SC, 1'b0, 2'd1, base, '1, '0, 1'b0, 1'b0));
        send_beat(make_req(OP_SC, 1'b1, 2'd2, base, '1, '0, 1'b0, 1'b0));
        send_beat(make_req(OP_SC, 1'b0, '1, base + 8, '1, '0, 1'b0, 1'b0));
        send_beat(make_req(OP_LR, 1'b1, '0, base, '0, '1, 1'b1, 1'b0));
        send_beat(make_req(OP_SC, 1'b1, '0, base, '1, '1, 1'b1, 1'b0));
        // every amo with sign-sensitive operands, alternating size
        for (int k = int'(OP_SWAP); k <= int'(OP_MAXU); k++)
            send_beat(make_req(4'(k), k[0], 2'(k), base + 64'(8 * k),
                               64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000, 1'b0, 1'b0));
        send_beat(make_req(OP_ADD, 1'b1, 2'd2, '1, '1, '1, 1'b1, 1'b0));
        send_beat(make_req(OP_MAXU, 1'b0, 2'd1, '0, '1, '1, 1'b0, 1'b1));
        send_beat(make_req(4'($urandom_range(int'(OP_MAXU) + 1, int'(OP_CODE_TOP))), 1'b1, '1,
                           '1, '1, '1, 1'b1, 1'b1));
        wait_idle();

        for (int p = 0; p < POOL_SIZE; p++)
            addr_pool[p] = {$urandom, $urandom} & ~64'h7;
        for (int h = 0; h < NUM_HARTS; h++) begin
            lr_addr[h] = addr_pool[0];
            lr_dbl[h] = 1'b0;
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_BEATS / 2)
                wait_idle();
            hart = HART_IDX_W'($urandom_range(0, NUM_HARTS - 1));
            pick = $urandom_range(0, 99);
            beat = make_req(OP_LR, 1'($urandom_range(0, 1)), hart,
                            addr_pool[$urandom_range(0, POOL_SIZE - 1)], rand_data(), rand_data(),
                            1'($urandom_range(0, 11) == 0), 1'($urandom_range(0, 11) == 0));
            if (pick < 40) begin
                lr_addr[hart] = beat.address;
                lr_dbl[hart] = beat.is_double;
            end else if (pick < 70) begin
                beat.req_type = OP_SC;
                if ($urandom_range(0, 3) != 0) begin
                    beat.address = lr_addr[hart];
                    beat.is_double = lr_dbl[hart];
                end
            end else if (pick < 95) begin
                beat.req_type = 4'($urandom_range(int'(OP_SWAP), int'(OP_MAXU)));
                if ($urandom_range(0, 1) == 0)
                    beat.address = {$urandom, $urandom};
            end else begin
                beat.req_type = 4'($urandom_range(int'(OP_MAXU) + 1, int'(OP_CODE_TOP)));
                beat.address = {$urandom, $urandom};
            end
            send_beat(beat);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rvamo_pkg.sv
rtl/rvamo_front.sv
rtl/rvamo_fifo.sv
rtl/rvamo_back.sv
rtl/riscv_atomic_amo_lr_sc_unit_top.sv
bench/riscv_atomic_amo_lr_sc_unit_top_test.sv
